[src/assert_macros.svh]
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[src/iup_pkg.sv]
// Types, constants and helper functions for the integer pixel upscaler.
`timescale 1ns / 1ps
`default_nettype none

package iup_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int SCALE_W   = 7;
  localparam int IWIDTH_W  = 11;
  localparam int HEIGHT_W  = 16;
  localparam int PIXEL_W   = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_PAD       = 2'd1,
    KIND_NOT_READY = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PIXELS,
    ST_PAD
  } state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_word_t;

  typedef struct packed {
    kind_t      item_kind;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic       image_end;
  } out_word_t;

  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    eff_scale = (s == '0) ? SCALE_W'(1) : s;
  endfunction

  function automatic logic [IWIDTH_W-1:0] eff_width(input logic [IWIDTH_W-1:0] w);
    logic [IWIDTH_W-1:0] w0;
    w0 = (w == '0) ? IWIDTH_W'(1) : w;
    eff_width = (w0 > IWIDTH_W'(MAX_WIDTH)) ? IWIDTH_W'(MAX_WIDTH) : w0;
  endfunction

  function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
    eff_height = (h == '0) ? HEIGHT_W'(1) : h;
  endfunction

  // Pad bytes that bring 3*w*s up to a multiple of four; only the low bits matter.
  function automatic logic [1:0] pad_bytes(input logic [IWIDTH_W-1:0] w,
                                           input logic [SCALE_W-1:0] s);
    logic [1:0] prod;
    logic [1:0] bytes;
    prod  = 2'(w[1:0] * s[1:0]);
    bytes = 2'(prod * 2'd3);
    pad_bytes = 2'(2'd0 - bytes);
  endfunction

endpackage

`default_nettype wire

[src/iup_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module iup_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/integer_pixel_upscaler_core.sv]
// Top level of the nearest-neighbor integer upscaler for 24-bit pixels.
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor integer upscaler. Load words (opcode 0) fill a line buffer
// with one input row of image_width pixels; once the row is complete, fetch
// words (opcode 1) return the output stream one word each: every buffered pixel
// repeated scale times, then zero pad bytes up to a 4-byte row boundary, with
// row_end on the last word of each output row. Each input row is sent scale
// times, then loading of the next row starts; image_end marks the last word of
// the image after image_height input rows. A fetch during loading returns a
// not-ready word; a load during emission is dropped and returns nothing.
// Throughput is one input word per clock unless the output sink stalls. A
// fetch result passes the registered read of the 1024 x 24 line-buffer RAM,
// held beside the middle stage, and then the output register. Line-buffer
// contents are not cleared at reset and need no clearing pass; pixel words
// only ever read entries written by the current row. Configuration writes take
// effect at once and belong in idle periods.

module integer_pixel_upscaler_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire iup_pkg::in_word_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output iup_pkg::out_word_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [iup_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [iup_pkg::CFG_W-1:0]            cfg_data
);

  import iup_pkg::*;

  // Configuration registers.
  logic [SCALE_W-1:0]  scale;
  logic [IWIDTH_W-1:0] image_width;
  logic [HEIGHT_W-1:0] image_height;

  // Sequencing state.
  state_t              state, state_next;
  logic [IWIDTH_W-1:0] load_count, load_count_next;
  logic [COL_W-1:0]    column_index, column_index_next;
  logic [SCALE_W-1:0]  repeat_across, repeat_across_next;
  logic [SCALE_W-1:0]  repeat_down, repeat_down_next;
  logic [1:0]          pad_count, pad_count_next;
  logic [HEIGHT_W-1:0] rows_done, rows_done_next;

  // Middle stage: result metadata waiting on the RAM read.
  logic  s1_valid;
  kind_t s1_kind;
  logic  s1_row_end;
  logic  s1_image_end;

  // Handshake.
  logic in_accept, is_load, is_fetch, s1_take, out_take;

  // Decode of the counters against the effective configuration.
  logic [SCALE_W-1:0]  s_eff;
  logic [IWIDTH_W-1:0] w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [1:0]          pad_n;
  logic [1:0]          pad_inc;
  logic [IWIDTH_W-1:0] load_inc;
  logic                ra_last, col_last, pad_last, down_last, rows_last, load_last;
  logic                row_done;

  // Result of the word being accepted.
  kind_t res_kind;
  logic  res_row_end;
  logic  res_image_end;

  // Line buffer.
  logic                ram_we, ram_re;
  logic [PIXEL_W-1:0]  ram_wdata, ram_rdata;

  // ---------------------------------------------------------------------------
  // Handshake: the middle stage moves on whenever the output register can
  // take a word, so a new word enters every cycle unless the sink stalls.
  // ---------------------------------------------------------------------------
  assign out_take  = !out_valid || out_ready;
  assign s1_take   = !s1_valid || out_take;
  assign in_ready  = s1_take;
  assign in_accept = in_valid && in_ready;
  assign is_load   = in_accept && (in_data.opcode == OP_LOAD);
  assign is_fetch  = in_accept && (in_data.opcode == OP_FETCH);

  // ---------------------------------------------------------------------------
  // Configuration: scale, width, height, written by index.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= SCALE_W'(1);
      image_width  <= IWIDTH_W'(1);
      image_height <= HEIGHT_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE:  scale        <= cfg_data[SCALE_W-1:0];
        REG_WIDTH:  image_width  <= cfg_data[IWIDTH_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // End-of-loop tests. Each is "reached or passed" so a register changed
  // mid-row still lets every counter finish.
  // ---------------------------------------------------------------------------
  always_comb begin
    s_eff     = eff_scale(scale);
    w_eff     = eff_width(image_width);
    h_eff     = eff_height(image_height);
    pad_n     = pad_bytes(w_eff, s_eff);
    pad_inc   = pad_count + 2'd1;
    load_inc  = load_count + IWIDTH_W'(1);
    ra_last   = ({1'b0, repeat_across} + (SCALE_W+1)'(1)) >= {1'b0, s_eff};
    down_last = ({1'b0, repeat_down} + (SCALE_W+1)'(1)) >= {1'b0, s_eff};
    col_last  = (IWIDTH_W'(column_index) + IWIDTH_W'(1)) >= w_eff;
    pad_last  = pad_inc >= pad_n;
    rows_last = ({1'b0, rows_done} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff};
    load_last = load_inc >= w_eff;
    // Last word of an output row: final pixel when no pad is due, or final pad.
    row_done  = is_fetch &&
                (((state == ST_PIXELS) && ra_last && col_last && (pad_n == 2'd0)) ||
                 ((state == ST_PAD) && pad_last));
  end

  // ---------------------------------------------------------------------------
  // Next state. Loads advance the fill count; fetches walk repeat, column and
  // pad counters; row finish resets the row, steps row repeat or row count.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next         = state;
    load_count_next    = load_count;
    column_index_next  = column_index;
    repeat_across_next = repeat_across;
    repeat_down_next   = repeat_down;
    pad_count_next     = pad_count;
    rows_done_next     = rows_done;

    case (state)
      ST_LOAD: begin
        if (is_load) begin
          load_count_next = load_inc;
          if (load_last) begin
            state_next         = ST_PIXELS;
            column_index_next  = '0;
            repeat_across_next = '0;
            repeat_down_next   = '0;
            pad_count_next     = '0;
          end
        end
      end
      ST_PIXELS: begin
        if (is_fetch) begin
          if (ra_last) begin
            repeat_across_next = '0;
            if (col_last) begin
              if (pad_n != 2'd0) begin
                state_next     = ST_PAD;
                pad_count_next = '0;
              end
            end else begin
              column_index_next = column_index + COL_W'(1);
            end
          end else begin
            repeat_across_next = repeat_across + SCALE_W'(1);
          end
        end
      end
      ST_PAD: begin
        if (is_fetch) begin
          pad_count_next = pad_inc;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase

    // Row finish overrides the per-state updates above.
    if (row_done) begin
      pad_count_next     = '0;
      column_index_next  = '0;
      repeat_across_next = '0;
      if (down_last) begin
        repeat_down_next = '0;
        state_next       = ST_LOAD;
        load_count_next  = '0;
        rows_done_next   = rows_last ? '0 : rows_done + HEIGHT_W'(1);
      end else begin
        repeat_down_next = repeat_down + SCALE_W'(1);
        state_next       = ST_PIXELS;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result of a fetch: kind and end marks, decided at acceptance.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state)
      ST_LOAD:   res_kind = KIND_NOT_READY;
      ST_PAD:    res_kind = KIND_PAD;
      ST_PIXELS: res_kind = KIND_PIXEL;
      default:   res_kind = KIND_NOT_READY;
    endcase
    res_row_end   = row_done;
    res_image_end = row_done && down_last && rows_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      load_count    <= '0;
      column_index  <= '0;
      repeat_across <= '0;
      repeat_down   <= '0;
      pad_count     <= '0;
      rows_done     <= '0;
    end else begin
      state         <= state_next;
      load_count    <= load_count_next;
      column_index  <= column_index_next;
      repeat_across <= repeat_across_next;
      repeat_down   <= repeat_down_next;
      pad_count     <= pad_count_next;
      rows_done     <= rows_done_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: write on a load while filling, read the current column on
  // every fetch. The read lands with the word in the middle stage.
  // ---------------------------------------------------------------------------
  assign ram_we    = is_load && (state == ST_LOAD) && (load_count < IWIDTH_W'(MAX_WIDTH));
  assign ram_re    = is_fetch;
  assign ram_wdata = {in_data.in_red, in_data.in_green, in_data.in_blue};

  iup_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count[COL_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (column_index),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Middle stage: hold while the output register is stalled; loads pass
  // through as empty slots.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= is_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_kind      <= res_kind;
      s1_row_end   <= res_row_end;
      s1_image_end <= res_image_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: pixel bytes only on pixel words, zero otherwise.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data.item_kind <= s1_kind;
      out_data.row_end   <= s1_row_end;
      out_data.image_end <= s1_image_end;
      if (s1_kind == KIND_PIXEL) begin
        out_data.out_blue  <= ram_rdata[7:0];
        out_data.out_green <= ram_rdata[15:8];
        out_data.out_red   <= ram_rdata[23:16];
      end else begin
        out_data.out_blue  <= '0;
        out_data.out_green <= '0;
        out_data.out_red   <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks. Read data only matters on pixel words; other fetches may read an
  // entry that holds nothing yet.
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_AT(a_load_counters_clear, clk, rst, (state == ST_LOAD) |-> (column_index == '0 && repeat_down == '0 && pad_count == '0), "counters not clear while loading")
  `ASSERT_AT(a_image_end_on_row_end, clk, rst, (out_valid && out_data.image_end) |-> out_data.row_end, "image end without row end")
  `ASSERT_NEVER(a_no_write_while_emitting, clk, rst, ram_we && (state != ST_LOAD), "line buffer written while emitting")
  `ASSERT_AT(a_mid_hold, clk, rst, (s1_valid && !out_take) |=> (s1_valid && $stable(s1_kind) && (s1_kind != KIND_PIXEL || $stable(ram_rdata))), "middle stage lost while stalled")

endmodule

`default_nettype wire
